FILE: hdl/barycentric_weights_3d_assert.svh
// Assertion macros shared by the block's modules.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef BARYCENTRIC_WEIGHTS_3D_ASSERT_SVH
`define BARYCENTRIC_WEIGHTS_3D_ASSERT_SVH

// The condition must never be true while out of reset.
`define BW_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("bw: forbidden condition seen");

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define BW_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bw: implication violated");

`endif

FILE: hdl/bw_pkg.sv
package bw_pkg;

  // Twelve coordinates per item: point, then vertices a, b and c, x first.
  localparam int NUM_COORDS  = 12;
  localparam int NUM_WEIGHTS = 3;

  // Depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } bw_qstat_t;

  // Width of one exact product of two dot products for a given coordinate
  // width: edges gain one bit, a product doubles, a three-term sum gains two.
  function automatic int bw_wide_width(input int coord_width);
    return 2 * (2 * (coord_width + 1) + 2);
  endfunction

endpackage

FILE: hdl/barycentric_weights_3d.sv
// Barycentric weights (u, v, w) of a query point against a triangle in 3-D,
// by the dot-product method with exact integer arithmetic. Each input beat
// carries the point and the three vertices as signed Q8.8 coordinates; each
// output beat carries the three weights as signed Q2.16, rounded half away
// from zero and saturated, with u = 1 - v - w taken before saturation. A
// triangle whose determinant is zero flags degenerate on out_tuser and
// returns all-zero weights. The block is fully pipelined and takes one beat
// per cycle sustained when the output side does not stall. The pipelined
// restoring divider in the back part makes one quotient bit per stage. The
// front part (edges, dot products, determinant and numerators) and the back
// part (division, weight assembly, saturation) each stall on their own,
// with a two-entry queue between them; the output is registered.
`include "barycentric_weights_3d_assert.svh"

module barycentric_weights_3d
  import bw_pkg::*;
#(
  parameter int COORD_WIDTH      = 16,
  parameter int WEIGHT_FRAC_BITS = 16,
  localparam int OW     = WEIGHT_FRAC_BITS + 2,
  localparam int IN_DW  = ((NUM_COORDS * COORD_WIDTH + 7) / 8) * 8,
  localparam int OUT_DW = ((NUM_WEIGHTS * OW + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // point_x, point_y, point_z, vert_a_x, vert_a_y, vert_a_z,
  // vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z
  input  logic [IN_DW-1:0]  in_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  // weight_u, weight_v, weight_w, then zero padding
  output logic [OUT_DW-1:0] out_tdata,
  // degenerate
  output logic              out_tuser
);

  localparam int WP = bw_wide_width(COORD_WIDTH);
  localparam int JW = 3 * WP + 1;

  // Jobs travel from front to back through the queue: determinant,
  // numerators of v and w, and the degenerate flag.
  logic          push, pop;
  logic [JW-1:0] job_in, job_out;
  bw_qstat_t     q_stat;
  logic [OW-1:0] wu, wv, ww;

  bw_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_coords(in_tdata[NUM_COORDS*COORD_WIDTH-1:0]),
    .q_stat   (q_stat),
    .push     (push),
    .job      (job_in)
  );

  bw_queue #(
    .WIDTH(JW)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_data(job_in),
    .pop    (pop),
    .rd_data(job_out),
    .stat   (q_stat)
  );

  bw_back #(
    .COORD_WIDTH     (COORD_WIDTH),
    .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .job_valid(!q_stat.empty),
    .job      (job_out),
    .pop      (pop),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_u    (wu),
    .out_v    (wv),
    .out_w    (ww),
    .out_deg  (out_tuser)
  );

  // The first weight sits in the lowest bits; spare high bits read zero.
  assign out_tdata = OUT_DW'({ww, wv, wu});

  // A degenerate triangle must never leave with nonzero weights.
  `BW_ASSERT_IMPLY(a_degenerate_zero, out_tvalid && out_tuser, out_tdata == '0)

endmodule

FILE: hdl/bw_front.sv
module bw_front
  import bw_pkg::*;
#(
  parameter int COORD_WIDTH = 16,
  localparam int WP = bw_wide_width(COORD_WIDTH),
  localparam int JW = 3 * WP + 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [NUM_COORDS*COORD_WIDTH-1:0] in_coords,
  input  bw_qstat_t                         q_stat,
  output logic                              push,
  output logic [JW-1:0]                     job
);

  localparam int EW  = COORD_WIDTH + 1;
  localparam int PW  = 2 * EW;
  localparam int DTW = PW + 2;
  localparam int LO  = DTW / 2;
  localparam int HI  = DTW - LO;
  localparam int NST = 6;

  // Dot products: 0 = e0.e0, 1 = e0.e1, 2 = e1.e1, 3 = e2.e0, 4 = e2.e1.
  localparam int DOT_A [5] = '{0, 0, 1, 2, 2};
  localparam int DOT_B [5] = '{0, 1, 1, 0, 1};
  // Wide products: d00*d11, d01*d01, d11*d20, d01*d21, d00*d21, d01*d20.
  localparam int MUL_X [6] = '{0, 1, 2, 1, 0, 1};
  localparam int MUL_Y [6] = '{2, 1, 3, 4, 4, 3};

  logic                  en;
  logic [NST-1:0]        vld_r;
  logic signed [EW-1:0]  e_r   [3][3];
  logic signed [EW-1:0]  e_nxt [3][3];
  logic signed [PW-1:0]  pr_r  [15];
  logic signed [DTW-1:0] dt_r  [5];
  logic signed [DTW-1:0] dt_nxt[5];
  logic signed [DTW+HI-1:0]   ph_r [6];
  logic signed [DTW+LO:0]     pl_r [6];
  logic signed [WP-1:0]  wp_r  [6];
  logic signed [WP-1:0]  den_r, nv_r, nw_r;

  assign en       = !vld_r[NST-1] || !q_stat.full;
  assign in_ready = en;
  assign push     = vld_r[NST-1] && !q_stat.full;
  assign job      = {(den_r == '0), nw_r, nv_r, den_r};

  // Edge vectors e0 = b - a, e1 = c - a, e2 = p - a.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e_nxt[0][i] = EW'($signed(in_coords[(6 + i)*COORD_WIDTH +: COORD_WIDTH]))
                  - EW'($signed(in_coords[(3 + i)*COORD_WIDTH +: COORD_WIDTH]));
      e_nxt[1][i] = EW'($signed(in_coords[(9 + i)*COORD_WIDTH +: COORD_WIDTH]))
                  - EW'($signed(in_coords[(3 + i)*COORD_WIDTH +: COORD_WIDTH]));
      e_nxt[2][i] = EW'($signed(in_coords[i*COORD_WIDTH +: COORD_WIDTH]))
                  - EW'($signed(in_coords[(3 + i)*COORD_WIDTH +: COORD_WIDTH]));
    end
  end

  always_comb begin
    for (int j = 0; j < 5; j++) begin
      dt_nxt[j] = DTW'(pr_r[3*j]) + DTW'(pr_r[3*j + 1]) + DTW'(pr_r[3*j + 2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_r <= e_nxt;
      for (int j = 0; j < 5; j++) begin
        for (int i = 0; i < 3; i++) begin
          pr_r[3*j + i] <= e_r[DOT_A[j]][i] * e_r[DOT_B[j]][i];
        end
      end
      dt_r <= dt_nxt;
      // Each wide product is split on the second operand into a signed
      // upper part and an unsigned lower part.
      for (int k = 0; k < 6; k++) begin
        ph_r[k] <= dt_r[MUL_X[k]] * $signed(dt_r[MUL_Y[k]][DTW-1:LO]);
        pl_r[k] <= dt_r[MUL_X[k]] * $signed({1'b0, dt_r[MUL_Y[k]][LO-1:0]});
      end
      for (int k = 0; k < 6; k++) begin
        wp_r[k] <= (WP'(ph_r[k]) <<< LO) + WP'(pl_r[k]);
      end
      den_r <= wp_r[0] - wp_r[1];
      nv_r  <= wp_r[2] - wp_r[3];
      nw_r  <= wp_r[4] - wp_r[5];
    end
  end

endmodule

FILE: hdl/bw_queue.sv
`include "barycentric_weights_3d_assert.svh"

module bw_queue
  import bw_pkg::*;
#(
  parameter int WIDTH = 217
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output bw_qstat_t        stat
);

  localparam int PB = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CB = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem_r [QUEUE_DEPTH];
  logic [PB-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CB-1:0]    cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == CB'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign rd_data    = mem_r[rd_ptr_r];

  always_comb begin
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + CB'(1);
      2'b01:   cnt_nxt = cnt_r - CB'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PB'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PB'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PB'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PB'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  `BW_ASSERT_NEVER(a_no_overflow, push && stat.full && !pop)
  `BW_ASSERT_NEVER(a_no_underflow, pop && stat.empty)
  `BW_ASSERT_NEVER(a_count_bound, cnt_r > CB'(QUEUE_DEPTH))

endmodule

FILE: hdl/bw_back.sv
module bw_back
  import bw_pkg::*;
#(
  parameter int COORD_WIDTH      = 16,
  parameter int WEIGHT_FRAC_BITS = 16,
  localparam int WP = bw_wide_width(COORD_WIDTH),
  localparam int JW = 3 * WP + 1,
  localparam int OW = WEIGHT_FRAC_BITS + 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  input  logic [JW-1:0] job,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [OW-1:0] out_u,
  output logic [OW-1:0] out_v,
  output logic [OW-1:0] out_w,
  output logic          out_deg
);

  localparam int F  = WEIGHT_FRAC_BITS;
  localparam int QW = WP + F;
  localparam int RW = WP;
  localparam int UW = QW + 3;

  logic en;

  // Divider pipeline; index 0 is the entry register, index QW the last step.
  logic [QW:0]   vld_r;
  logic [RW-1:0] den_r   [QW+1];
  logic [RW-1:0] rem_v_r [QW+1];
  logic [RW-1:0] rem_w_r [QW+1];
  logic [QW-1:0] q_v_r   [QW+1];
  logic [QW-1:0] q_w_r   [QW+1];
  logic          neg_v_r [QW+1];
  logic          neg_w_r [QW+1];
  logic          deg_r   [QW+1];

  logic [RW-1:0]        den_in;
  logic signed [WP-1:0] nv_in, nw_in;
  logic [WP-1:0]        mag_v, mag_w;
  logic [QW-1:0]        dvd_v, dvd_w;

  logic                 a_vld_r, b_vld_r, out_valid_r;
  logic signed [QW:0]   a_v_r, a_w_r;
  logic                 a_deg_r, b_deg_r;
  logic signed [UW-1:0] b_u_r, b_v_r, b_w_r;
  logic [OW-1:0]        out_u_r, out_v_r, out_w_r;
  logic                 out_deg_r;

  function automatic logic [OW-1:0] sat(input logic signed [UW-1:0] x);
    logic hi, lo;
    hi = !x[UW-1] && (|x[UW-2:OW-1]);
    lo = x[UW-1] && !(&x[UW-2:OW-1]);
    priority if (hi) begin
      sat = {1'b0, {(OW-1){1'b1}}};
    end else if (lo) begin
      sat = {1'b1, {(OW-1){1'b0}}};
    end else begin
      sat = x[OW-1:0];
    end
  endfunction

  assign en        = !out_valid_r || out_ready;
  assign pop       = en && job_valid;
  assign out_valid = out_valid_r;
  assign out_u     = out_u_r;
  assign out_v     = out_v_r;
  assign out_w     = out_w_r;
  assign out_deg   = out_deg_r;

  // Dividend is |n| * 2^F plus half the divisor, which rounds halves away
  // from zero once the sign is put back.
  always_comb begin
    den_in = job[RW-1:0];
    nv_in  = $signed(job[2*WP-1:WP]);
    nw_in  = $signed(job[3*WP-1:2*WP]);
    mag_v  = nv_in[WP-1] ? WP'(-nv_in) : WP'(nv_in);
    mag_w  = nw_in[WP-1] ? WP'(-nw_in) : WP'(nw_in);
    dvd_v  = {mag_v, {F{1'b0}}} + QW'(den_in >> 1);
    dvd_w  = {mag_w, {F{1'b0}}} + QW'(den_in >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      a_vld_r     <= 1'b0;
      b_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[QW-1:0], job_valid};
      a_vld_r     <= vld_r[QW];
      b_vld_r     <= a_vld_r;
      out_valid_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0]   <= den_in;
      rem_v_r[0] <= '0;
      rem_w_r[0] <= '0;
      q_v_r[0]   <= dvd_v;
      q_w_r[0]   <= dvd_w;
      neg_v_r[0] <= nv_in[WP-1];
      neg_w_r[0] <= nw_in[WP-1];
      deg_r[0]   <= job[JW-1];
    end
  end

  // One restoring step per stage: the dividend shifts out of the top of q
  // while quotient bits shift in at the bottom.
  for (genvar s = 0; s < QW; s++) begin : g_div
    logic [RW:0] sh_v, sh_w, df_v, df_w;
    always_comb begin
      sh_v = {rem_v_r[s], q_v_r[s][QW-1]};
      sh_w = {rem_w_r[s], q_w_r[s][QW-1]};
      df_v = sh_v - {1'b0, den_r[s]};
      df_w = sh_w - {1'b0, den_r[s]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        den_r[s+1]   <= den_r[s];
        rem_v_r[s+1] <= df_v[RW] ? sh_v[RW-1:0] : df_v[RW-1:0];
        rem_w_r[s+1] <= df_w[RW] ? sh_w[RW-1:0] : df_w[RW-1:0];
        q_v_r[s+1]   <= {q_v_r[s][QW-2:0], !df_v[RW]};
        q_w_r[s+1]   <= {q_w_r[s][QW-2:0], !df_w[RW]};
        neg_v_r[s+1] <= neg_v_r[s];
        neg_w_r[s+1] <= neg_w_r[s];
        deg_r[s+1]   <= deg_r[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_v_r   <= neg_v_r[QW] ? -$signed({1'b0, q_v_r[QW]}) : $signed({1'b0, q_v_r[QW]});
      a_w_r   <= neg_w_r[QW] ? -$signed({1'b0, q_w_r[QW]}) : $signed({1'b0, q_w_r[QW]});
      a_deg_r <= deg_r[QW];

      b_v_r   <= UW'(a_v_r);
      b_w_r   <= UW'(a_w_r);
      b_u_r   <= (UW'(1) <<< F) - UW'(a_v_r) - UW'(a_w_r);
      b_deg_r <= a_deg_r;

      out_deg_r <= b_deg_r;
      out_u_r   <= b_deg_r ? '0 : sat(b_u_r);
      out_v_r   <= b_deg_r ? '0 : sat(b_v_r);
      out_w_r   <= b_deg_r ? '0 : sat(b_w_r);
    end
  end

endmodule
